// File: rtl/sod_pkg.sv
// ----------------------------------------------------------------------------
// Stationary object detector package
// Shared constants, register indexes and types of the stationary object detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sod_pkg;

	// Geometry defaults and fixed sizes.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 512;
	localparam int HIST_FRAMES    = 5;
	localparam int AGREE_W        = 3;
	localparam int FRAMES_W       = 3;

	// Field and register widths.
	localparam int MASK_W   = 8;
	localparam int X_CFG_W  = 11;
	localparam int Y_CFG_W  = 10;
	localparam int COUNT_W  = 20;
	localparam int SUM_W    = COUNT_W + 1;
	localparam int RATIO_W  = 4;
	localparam int PROD_W   = COUNT_W + RATIO_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [MASK_W-1:0] FG_VALUE = 8'hFF;

	// Output queue depth; also bounds the number of results in flight.
	localparam int FIFO_DEPTH = 5;

	localparam logic [COUNT_W-1:0]      COUNT_MAX = '1;
	localparam logic signed [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ROI_X_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_X_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_Y_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_Y_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FG       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_TENTHS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_AGREEING = 3'd7;

	typedef struct packed {
		logic [X_CFG_W-1:0]  roi_x_min;
		logic [X_CFG_W-1:0]  roi_x_max;
		logic [Y_CFG_W-1:0]  roi_y_min;
		logic [Y_CFG_W-1:0]  roi_y_max;
		logic [X_CFG_W-1:0]  frame_width;
		logic [COUNT_W-1:0]  min_foreground;
		logic [RATIO_W-1:0]  ratio_tenths;
		logic [AGREE_W-1:0]  min_agreeing;
	} cfg_t;

	// Per-pixel control bits leaving the raster stage.
	typedef struct packed {
		logic fg;
		logic eof;
		logic in_roi;
	} pix_ctl_t;

	// Frame totals handed to the evaluation stage at the end of a frame.
	typedef struct packed {
		logic                                valid;
		logic                                ready;
		logic [COUNT_W-1:0]                  count;
		logic [HIST_FRAMES-1:0][SUM_W-1:0]   sums;
	} snap_t;

	typedef struct packed {
		logic               object_present;
		logic [AGREE_W-1:0] agreeing_frames;
		logic               history_ready;
	} res_t;

endpackage

// File: rtl/stationary_object_detector_top.sv
// ----------------------------------------------------------------------------
// Stationary object detector
// Per-pixel foreground history over five frames with a per-frame object decision.
// ----------------------------------------------------------------------------
// The block takes one mask pixel per clock in raster order while pixel_stall
// is low, and answers each word that carries end_of_frame with one result
// word. A pixel passes through three steps: the raster step forms the history
// address and the region test, the memory step reads, shifts and writes back
// the five-bit history word, while the frame totals are updated, in a single
// memory of 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries, and the evaluation
// step judges the registered totals before the result enters a five-word
// output queue. The read-modify-write on the history memory sets the rate of
// one pixel per clock; back-to-back accesses to the same entry are served by
// forwarding the word just written. pixel_stall rises only while five
// results are held or in flight, which happens only once the result side has
// stalled; even a run of single-pixel frames flows at one pixel per clock.
// The history memory has no clearing pass and is undefined until the first
// five frames of unchanged geometry have passed; no object is reported during
// those frames. Registers are to be written while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stationary_object_detector_top #(
	parameter int MAX_WIDTH  = sod_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sod_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	input  logic [sod_pkg::MASK_W-1:0]      mask_value,
	input  logic                            end_of_frame,

	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            object_present,
	output logic [sod_pkg::AGREE_W-1:0]     agreeing_frames,
	output logic                            history_ready,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sod_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sod_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sod_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = COL_W + ROW_W;
	localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

	cfg_t              cfg_q;
	logic [PEND_W-1:0] pend_q;

	logic              pix_accept;
	logic              res_accept;
	logic [ADDR_W-1:0] pix_addr;
	pix_ctl_t          pix_ctl;
	snap_t             snap;
	logic              res_push;
	res_t              res_new;
	res_t              res_head;

	// Configuration registers; every index of the port maps to a register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roi_x_min      <= X_CFG_W'(0);
			cfg_q.roi_x_max      <= X_CFG_W'(1024);
			cfg_q.roi_y_min      <= Y_CFG_W'(0);
			cfg_q.roi_y_max      <= Y_CFG_W'(512);
			cfg_q.frame_width    <= X_CFG_W'(640);
			cfg_q.min_foreground <= COUNT_W'(70);
			cfg_q.ratio_tenths   <= RATIO_W'(7);
			cfg_q.min_agreeing   <= AGREE_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROI_X_MIN:    cfg_q.roi_x_min      <= cfg_data[X_CFG_W-1:0];
				REG_ROI_X_MAX:    cfg_q.roi_x_max      <= cfg_data[X_CFG_W-1:0];
				REG_ROI_Y_MIN:    cfg_q.roi_y_min      <= cfg_data[Y_CFG_W-1:0];
				REG_ROI_Y_MAX:    cfg_q.roi_y_max      <= cfg_data[Y_CFG_W-1:0];
				REG_FRAME_WIDTH:  cfg_q.frame_width    <= cfg_data[X_CFG_W-1:0];
				REG_MIN_FG:       cfg_q.min_foreground <= cfg_data[COUNT_W-1:0];
				REG_RATIO_TENTHS: cfg_q.ratio_tenths   <= cfg_data[RATIO_W-1:0];
				REG_MIN_AGREEING: cfg_q.min_agreeing   <= cfg_data[AGREE_W-1:0];
				default:          cfg_q                <= cfg_q;
			endcase
		end
	end

	// Results owed: frame-end words taken but not yet delivered. Bounding this
	// by the queue depth guarantees the queue never overflows.
	assign pixel_stall = (pend_q >= PEND_W'(FIFO_DEPTH));
	assign pix_accept  = pixel_valid && !pixel_stall;
	assign res_accept  = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if ((pix_accept && end_of_frame) && !res_accept) begin
			pend_q <= pend_q + PEND_W'(1);
		end else if (!(pix_accept && end_of_frame) && res_accept) begin
			pend_q <= pend_q - PEND_W'(1);
		end
	end

	sod_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COL_W      (COL_W),
		.ROW_W      (ROW_W)
	) u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (pix_accept),
		.mask_value   (mask_value),
		.end_of_frame (end_of_frame),
		.cfg          (cfg_q),
		.addr         (pix_addr),
		.ctl          (pix_ctl)
	);

	sod_accum #(
		.ADDR_W (ADDR_W)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (pix_accept),
		.addr   (pix_addr),
		.ctl    (pix_ctl),
		.snap   (snap)
	);

	sod_judge u_judge (
		.clk            (clk),
		.arst_n         (arst_n),
		.snap           (snap),
		.min_foreground (cfg_q.min_foreground),
		.ratio_tenths   (cfg_q.ratio_tenths),
		.min_agreeing   (cfg_q.min_agreeing),
		.push           (res_push),
		.res            (res_new)
	);

	sod_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_new),
		.pop       (res_accept),
		.not_empty (result_valid),
		.head      (res_head)
	);

	assign object_present  = res_head.object_present;
	assign agreeing_frames = res_head.agreeing_frames;
	assign history_ready   = res_head.history_ready;

endmodule

// File: rtl/sod_raster.sv
// ----------------------------------------------------------------------------
// Raster tracker
// Keeps the pixel position, forms the history address and the region test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sod_raster #(
	parameter int MAX_WIDTH  = sod_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sod_pkg::DEF_MAX_HEIGHT,
	parameter int COL_W      = $clog2(MAX_WIDTH),
	parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [sod_pkg::MASK_W-1:0]  mask_value,
	input  logic                        end_of_frame,
	input  sod_pkg::cfg_t               cfg,
	output logic [COL_W+ROW_W-1:0]      addr,
	output sod_pkg::pix_ctl_t           ctl
);
	import sod_pkg::*;

	localparam int XW = (COL_W + 1 > X_CFG_W) ? COL_W + 1 : X_CFG_W;
	localparam int YW = (ROW_W + 1 > Y_CFG_W) ? ROW_W + 1 : Y_CFG_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [XW-1:0]    col_x, col_next_x;
	logic [YW-1:0]    row_y;
	logic             row_end;

	assign col_x      = XW'(col_q);
	assign col_next_x = col_x + XW'(1);
	assign row_y      = YW'(row_q);
	assign row_end    = (col_next_x >= XW'(cfg.frame_width))
		|| (col_q == COL_W'(MAX_WIDTH - 1));

	assign addr       = {row_q, col_q};
	assign ctl.fg     = (mask_value == FG_VALUE);
	assign ctl.eof    = end_of_frame;
	assign ctl.in_roi = (col_x >= XW'(cfg.roi_x_min)) && (col_x < XW'(cfg.roi_x_max))
		&& (row_y >= YW'(cfg.roi_y_min)) && (row_y < YW'(cfg.roi_y_max));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (end_of_frame) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				if (row_q != ROW_W'(MAX_HEIGHT - 1)) begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

// File: rtl/sod_accum.sv
// ----------------------------------------------------------------------------
// History memory and frame accumulators
// Read-modify-write of the per-pixel history word and update of the frame totals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sod_accum #(
	parameter int ADDR_W = 19
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [ADDR_W-1:0]    addr,
	input  sod_pkg::pix_ctl_t    ctl,
	output sod_pkg::snap_t       snap
);
	import sod_pkg::*;

	localparam int DEPTH = 1 << ADDR_W;

	logic [HIST_FRAMES-1:0] hist_mem [DEPTH];

	logic                   valid_s1;
	logic [ADDR_W-1:0]      addr_s1;
	pix_ctl_t               ctl_s1;
	logic                   fwd_s1;
	logic [HIST_FRAMES-1:0] rd_s1;
	logic [HIST_FRAMES-1:0] wdata_q;

	logic [COUNT_W-1:0]      count_q;
	logic signed [SUM_W-1:0] sums_q [HIST_FRAMES];
	logic [FRAMES_W-1:0]     frames_q;
	snap_t                   snap_s2;

	logic [HIST_FRAMES-1:0]  old_bits, new_bits;
	logic                    hit;
	logic [COUNT_W-1:0]      count_nxt;
	logic signed [SUM_W-1:0] sums_nxt [HIST_FRAMES];

	// The word written in the previous cycle is not yet visible to a read of the same entry.
	assign old_bits = fwd_s1 ? wdata_q : rd_s1;
	assign new_bits = {old_bits[HIST_FRAMES-2:0], ctl_s1.fg};
	assign hit      = ctl_s1.in_roi && ctl_s1.fg;

	always_comb begin
		count_nxt = count_q;
		if (hit && count_q != COUNT_MAX) begin
			count_nxt = count_q + COUNT_W'(1);
		end
		for (int k = 0; k < HIST_FRAMES; k++) begin
			sums_nxt[k] = sums_q[k];
			if (hit) begin
				if (old_bits[k]) begin
					if (sums_q[k] != SUM_MAX) begin
						sums_nxt[k] = sums_q[k] + SUM_W'(1);
					end
				end else if (sums_q[k] != SUM_MIN) begin
					sums_nxt[k] = sums_q[k] - SUM_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= hist_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hist_mem[addr_s1] <= new_bits;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			wdata_q <= new_bits;
		end
		if (accept) begin
			addr_s1 <= addr;
			ctl_s1  <= ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			count_q  <= '0;
			frames_q <= '0;
			snap_s2  <= '0;
			for (int k = 0; k < HIST_FRAMES; k++) begin
				sums_q[k] <= '0;
			end
		end else begin
			valid_s1 <= accept;
			fwd_s1   <= accept && valid_s1 && (addr_s1 == addr);
			snap_s2.valid <= valid_s1 && ctl_s1.eof;
			if (valid_s1 && ctl_s1.eof) begin
				snap_s2.ready <= (frames_q >= FRAMES_W'(HIST_FRAMES));
				snap_s2.count <= count_nxt;
				for (int k = 0; k < HIST_FRAMES; k++) begin
					snap_s2.sums[k] <= sums_nxt[k];
					sums_q[k]       <= '0;
				end
				count_q <= '0;
				if (frames_q < FRAMES_W'(HIST_FRAMES)) begin
					frames_q <= frames_q + FRAMES_W'(1);
				end
			end else if (valid_s1) begin
				count_q <= count_nxt;
				for (int k = 0; k < HIST_FRAMES; k++) begin
					sums_q[k] <= sums_nxt[k];
				end
			end
		end
	end

	assign snap = snap_s2;

endmodule

// File: rtl/sod_judge.sv
// ----------------------------------------------------------------------------
// Frame evaluation
// Tests each past frame for agreement and decides on the object flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sod_judge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sod_pkg::snap_t               snap,
	input  logic [sod_pkg::COUNT_W-1:0]  min_foreground,
	input  logic [sod_pkg::RATIO_W-1:0]  ratio_tenths,
	input  logic [sod_pkg::AGREE_W-1:0]  min_agreeing,
	output logic                         push,
	output sod_pkg::res_t                res
);
	import sod_pkg::*;

	logic                   valid_s3;
	logic                   ready_s3;
	logic                   cnt_ok_s3;
	logic [HIST_FRAMES-1:0] nonneg_s3;
	logic [PROD_W-1:0]      p10_s3 [HIST_FRAMES];
	logic [PROD_W-1:0]      pr_s3;
	logic                   object_flag_q;

	logic [AGREE_W-1:0]     agree;
	logic                   flag_nxt;

	always_ff @(posedge clk) begin
		if (snap.valid) begin
			ready_s3  <= snap.ready;
			cnt_ok_s3 <= (snap.count >= min_foreground);
			pr_s3     <= PROD_W'(ratio_tenths) * PROD_W'(snap.count);
			for (int k = 0; k < HIST_FRAMES; k++) begin
				nonneg_s3[k] <= !snap.sums[k][SUM_W-1];
				// Ten times the sum as a shift-and-add; only used when the sum is not negative.
				p10_s3[k] <= (PROD_W'(snap.sums[k][SUM_W-2:0]) << 3)
					+ (PROD_W'(snap.sums[k][SUM_W-2:0]) << 1);
			end
		end
	end

	always_comb begin
		agree = '0;
		for (int k = 0; k < HIST_FRAMES; k++) begin
			if (cnt_ok_s3 && nonneg_s3[k] && (p10_s3[k] > pr_s3)) begin
				agree = agree + AGREE_W'(1);
			end
		end
		flag_nxt = ready_s3 ? (agree >= min_agreeing) : object_flag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3      <= 1'b0;
			object_flag_q <= 1'b0;
		end else begin
			valid_s3 <= snap.valid;
			if (valid_s3) begin
				object_flag_q <= flag_nxt;
			end
		end
	end

	assign push                = valid_s3;
	assign res.object_present  = flag_nxt;
	assign res.agreeing_frames = ready_s3 ? agree : '0;
	assign res.history_ready   = ready_s3;

endmodule

// File: rtl/sod_result_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small first-in first-out buffer between the evaluation and the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sod_result_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sod_pkg::res_t  push_data,
	input  logic           pop,
	output logic           not_empty,
	output sod_pkg::res_t  head
);
	import sod_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	res_t             buf_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	assign not_empty = (fill_q != '0);
	assign head      = buf_q[rd_ptr_q];

endmodule

// File: rtl/sod_checker.sv
// ----------------------------------------------------------------------------
// Stationary object detector port checker
// Assertions on the result port of the detector, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sod_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            pixel_valid,
	input logic                            pixel_stall,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic                            object_present,
	input logic [sod_pkg::AGREE_W-1:0]     agreeing_frames,
	input logic                            history_ready
);
	import sod_pkg::*;

	// A stalled result word stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word withdrawn while stalled");

	// A stalled result word keeps its contents.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(object_present)
			&& $stable(agreeing_frames) && $stable(history_ready))
		else $error("result word changed while stalled");

	// During warm-up no frame is judged and no object is reported.
	a_warmup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !history_ready |-> !object_present && agreeing_frames == '0)
		else $error("evaluation reported before history is complete");

	// Never more agreeing frames than frames held.
	a_agree_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> agreeing_frames <= AGREE_W'(HIST_FRAMES))
		else $error("agreeing frame count out of range");

	// Once a result has been taken, the input side is not held off by results
	// that have already left.
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && $past(!result_valid) && $past(!result_valid, 2)
			&& $past(!result_valid, 3) && $past(!pixel_valid, 1)
			&& $past(!pixel_valid, 2) && $past(!pixel_valid, 3)
			&& $past(arst_n, 3) |-> !pixel_stall)
		else $error("input stalled with no results owed");

endmodule

bind stationary_object_detector_top sod_checker u_sod_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pixel_valid     (pixel_valid),
	.pixel_stall     (pixel_stall),
	.result_valid    (result_valid),
	.result_stall    (result_stall),
	.object_present  (object_present),
	.agreeing_frames (agreeing_frames),
	.history_ready   (history_ready)
);

// File: bench/tb_stationary_object_detector_top.sv
// ----------------------------------------------------------------------------
// Stationary object detector testbench
// Streams mask frames under random flow control and checks every frame verdict.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the per-pixel history, the raster
// position, the frame totals and the register settings. It works out the
// verdict expected at each frame end. Plain tasks drive the pixel and register
// channels, and the receiver stalls on a pattern of its own. The run has three
// parts: a directed opening through the warm-up frames, then phases of
// similar frames with random content, then a final drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class verdict_scoreboard;
	sod_pkg::cfg_t settings;
	bit [sod_pkg::HIST_FRAMES-1:0] hist_mem [sod_pkg::DEF_MAX_WIDTH * sod_pkg::DEF_MAX_HEIGHT];
	byte unsigned writes_seen [sod_pkg::DEF_MAX_WIDTH * sod_pkg::DEF_MAX_HEIGHT];
	int col;
	int row;
	int fg_count;
	int agree_sum [sod_pkg::HIST_FRAMES];
	int frames_seen;
	bit object_flag;
	sod_pkg::res_t pending_verdicts [$];
	int mismatches;

	function new();
		settings = '{roi_x_min: 11'd0, roi_x_max: 11'd1024, roi_y_min: 10'd0,
			roi_y_max: 10'd512, frame_width: 11'd640, min_foreground: 20'd70,
			ratio_tenths: 4'd7, min_agreeing: 3'd4};
	endfunction

	function void write_reg(logic [sod_pkg::CFG_IDX_W-1:0] idx,
			logic [sod_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			sod_pkg::REG_ROI_X_MIN:    settings.roi_x_min = value[sod_pkg::X_CFG_W-1:0];
			sod_pkg::REG_ROI_X_MAX:    settings.roi_x_max = value[sod_pkg::X_CFG_W-1:0];
			sod_pkg::REG_ROI_Y_MIN:    settings.roi_y_min = value[sod_pkg::Y_CFG_W-1:0];
			sod_pkg::REG_ROI_Y_MAX:    settings.roi_y_max = value[sod_pkg::Y_CFG_W-1:0];
			sod_pkg::REG_FRAME_WIDTH:  settings.frame_width = value[sod_pkg::X_CFG_W-1:0];
			sod_pkg::REG_MIN_FG:       settings.min_foreground = value;
			sod_pkg::REG_RATIO_TENTHS: settings.ratio_tenths = value[sod_pkg::RATIO_W-1:0];
			default:                   settings.min_agreeing = value[sod_pkg::AGREE_W-1:0];
		endcase
	endfunction

	// True when the next pixel may safely be foreground: either no verdict will
	// be drawn from this frame, or its history word has been filled completely.
	function bit history_settled();
		return frames_seen < sod_pkg::HIST_FRAMES ||
			writes_seen[row * sod_pkg::DEF_MAX_WIDTH + col] >= sod_pkg::HIST_FRAMES;
	endfunction

	function int pending();
		return pending_verdicts.size();
	endfunction

	function void take_pixel(logic [sod_pkg::MASK_W-1:0] mask, logic eof);
		bit fg;
		int addr;
		bit [sod_pkg::HIST_FRAMES-1:0] old;
		int agreeing;
		sod_pkg::res_t verdict;
		fg = (mask == sod_pkg::FG_VALUE);
		addr = row * sod_pkg::DEF_MAX_WIDTH + col;
		old = hist_mem[addr];
		if (fg && col >= int'(settings.roi_x_min) && col < int'(settings.roi_x_max) &&
				row >= int'(settings.roi_y_min) && row < int'(settings.roi_y_max)) begin
			if (fg_count < (1 << sod_pkg::COUNT_W) - 1)
				fg_count++;
			for (int k = 0; k < sod_pkg::HIST_FRAMES; k++) begin
				if (old[k]) begin
					if (agree_sum[k] < (1 << (sod_pkg::SUM_W - 1)) - 1)
						agree_sum[k]++;
				end else if (agree_sum[k] > -(1 << (sod_pkg::SUM_W - 1))) begin
					agree_sum[k]--;
				end
			end
		end
		hist_mem[addr] = {old[sod_pkg::HIST_FRAMES-2:0], fg};
		if (writes_seen[addr] < sod_pkg::HIST_FRAMES)
			writes_seen[addr]++;

		if (col + 1 >= int'(settings.frame_width) || col + 1 >= sod_pkg::DEF_MAX_WIDTH) begin
			col = 0;
			if (row + 1 < sod_pkg::DEF_MAX_HEIGHT)
				row++;
		end else begin
			col++;
		end

		if (!eof)
			return;

		agreeing = 0;
		if (frames_seen >= sod_pkg::HIST_FRAMES) begin
			for (int k = 0; k < sod_pkg::HIST_FRAMES; k++) begin
				if (fg_count >= int'(settings.min_foreground) && agree_sum[k] >= 0 &&
						10 * longint'(agree_sum[k]) > longint'(settings.ratio_tenths) * fg_count)
					agreeing++;
			end
			object_flag = (agreeing >= int'(settings.min_agreeing));
		end
		verdict.object_present = object_flag;
		verdict.agreeing_frames = 3'(agreeing);
		verdict.history_ready = (frames_seen >= sod_pkg::HIST_FRAMES);
		pending_verdicts.push_back(verdict);
		if (frames_seen < sod_pkg::HIST_FRAMES)
			frames_seen++;
		col = 0;
		row = 0;
		fg_count = 0;
		foreach (agree_sum[k])
			agree_sum[k] = 0;
	endfunction

	function void check_verdict(sod_pkg::res_t got);
		sod_pkg::res_t want;
		if (pending_verdicts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("verdict word with no frame end waiting: object %0d agreeing %0d ready %0d",
					got.object_present, got.agreeing_frames, got.history_ready);
			return;
		end
		want = pending_verdicts.pop_front();
		if (got.object_present !== want.object_present ||
				got.agreeing_frames !== want.agreeing_frames ||
				got.history_ready !== want.history_ready) begin
			mismatches++;
			if (mismatches <= 10)
				$display("verdict mismatch: expected object %0d agreeing %0d ready %0d, got object %0d agreeing %0d ready %0d",
					want.object_present, want.agreeing_frames, want.history_ready,
					got.object_present, got.agreeing_frames, got.history_ready);
		end
	endfunction
endclass

module tb_stationary_object_detector_top;

	localparam int ITEM_TARGET   = 1950;
	localparam int SETTLE_CYCLES = 10;
	localparam int LIMIT_CYCLES  = 400000;

	// Mask values of the directed opening: six four-pixel frames.
	localparam logic [sod_pkg::MASK_W-1:0] OPENING [24] = '{
		8'd255, 8'd0,   8'd255, 8'd254,
		8'd255, 8'd255, 8'd1,   8'd128,
		8'd255, 8'd255, 8'd127, 8'd255,
		8'd0,   8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd64,
		8'd255, 8'd255, 8'd255, 8'd255};

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURST} stall_mode_t;

	logic clk;
	logic arst_n = 1'b0;

	logic pixel_valid = 1'b0;
	logic pixel_stall;
	logic [sod_pkg::MASK_W-1:0] mask_value = '0;
	logic end_of_frame = 1'b0;

	logic result_valid;
	logic result_stall = 1'b0;
	logic object_present;
	logic [sod_pkg::AGREE_W-1:0] agreeing_frames;
	logic history_ready;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sod_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sod_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	verdict_scoreboard sb = new();

	int pixels_sent = 0;
	int cycle_count = 0;
	int burst_left = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int mode_left = 0;
	int hold_left = 0;
	logic stall_next;

	stationary_object_detector_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.pixel_valid     (pixel_valid),
		.pixel_stall     (pixel_stall),
		.mask_value      (mask_value),
		.end_of_frame    (end_of_frame),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.object_present  (object_present),
		.agreeing_frames (agreeing_frames),
		.history_ready   (history_ready),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset is held at the start and released on a falling edge, well away
	// from the rising edge that the block samples on.
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog: a lost or stuck word would otherwise hang the run for ever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("stationary_object_detector_top test failed");
			$finish;
		end
	end

	// Result side. The stall line changes only on the falling edge and follows
	// one of four moods at a time: none at all, occasional, mostly stalled, or
	// long stretches alternating between stalled and free. The heavy and
	// burst moods fill the output queue, so back-pressure reaches the pixels.
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 120);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_NONE:  stall_next = 1'b0;
			STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
			STALL_HEAVY: stall_next = ($urandom_range(0, 9) < 7);
			default: begin
				if (hold_left == 0) begin
					stall_next = !result_stall;
					hold_left = stall_next ? $urandom_range(1, 20) : $urandom_range(1, 10);
				end else begin
					hold_left--;
					stall_next = result_stall;
				end
			end
		endcase
		result_stall <= stall_next;
	end

	// Every verdict word accepted on a rising edge goes straight to the
	// scoreboard. The field order of the concatenation matches the packed
	// result type of the package.
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0)
			sb.check_verdict({object_present, agreeing_frames, history_ready});
	end

	// One register write. It is entered on a falling edge and returns on the
	// falling edge after the write was taken. The valid line stays high, so
	// that writes may follow back to back.
	task automatic write_register(input logic [sod_pkg::CFG_IDX_W-1:0] idx,
			input logic [sod_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	// All eight registers are written on every change of settings. The block
	// is idle at that point, so the order of the writes does not matter.
	task automatic apply_settings(input sod_pkg::cfg_t c);
		write_register(sod_pkg::REG_ROI_X_MIN, c.roi_x_min);
		write_register(sod_pkg::REG_ROI_X_MAX, c.roi_x_max);
		write_register(sod_pkg::REG_ROI_Y_MIN, c.roi_y_min);
		write_register(sod_pkg::REG_ROI_Y_MAX, c.roi_y_max);
		write_register(sod_pkg::REG_FRAME_WIDTH, c.frame_width);
		write_register(sod_pkg::REG_MIN_FG, c.min_foreground);
		write_register(sod_pkg::REG_RATIO_TENTHS, c.ratio_tenths);
		write_register(sod_pkg::REG_MIN_AGREEING, c.min_agreeing);
		cfg_valid <= 1'b0;
	endtask

	// One pixel word. The sender works in bursts of random length. Between
	// bursts it drops valid for a random gap, which is sometimes zero, so
	// that long unbroken runs also occur. The scoreboard learns of the
	// word at the edge that accepts it. Its state is therefore current when
	// the next word is chosen.
	task automatic send_pixel(input logic [sod_pkg::MASK_W-1:0] mask, input logic eof);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		pixel_valid <= 1'b1;
		mask_value <= mask;
		end_of_frame <= eof;
		do @(posedge clk); while (pixel_stall !== 1'b0);
		sb.take_pixel(mask, eof);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Waits until every expected verdict has come back. The block may still
	// hold a pixel that ends no frame, so a settling wait follows.
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Picks a mask value. A foreground pixel is only sent during the warm-up or
	// where its history word has been written at least five times. Otherwise the
	// undefined contents of the history memory could reach a verdict. Values
	// below 255 span every bit pattern, both extremes among them.
	function automatic logic [sod_pkg::MASK_W-1:0] mask_for(input bit want_fg);
		if (want_fg && sb.history_settled())
			return sod_pkg::FG_VALUE;
		case ($urandom_range(0, 3))
			0:       return 8'd0;
			1:       return 8'd254;
			default: return 8'($urandom_range(0, 254));
		endcase
	endfunction

	initial begin
		sod_pkg::cfg_t plan;
		bit scene [64];
		int phase;
		int frame_len;
		int frame_total;
		int len_now;
		int drop_pct;
		int fill_pct;
		bit want_fg;

		wait (arst_n === 1'b1);
		@(negedge clk);

		// Directed opening: four-pixel frames on one row, with the region of
		// interest covering the whole picture and no least count. The first
		// five frames are the warm-up and must report nothing. The sixth is
		// the first one that is judged. A single-pixel frame follows it.
		plan = '{roi_x_min: 11'd0, roi_x_max: 11'd1024, roi_y_min: 10'd0,
			roi_y_max: 10'd512, frame_width: 11'd4, min_foreground: 20'd0,
			ratio_tenths: 4'd7, min_agreeing: 3'd4};
		apply_settings(plan);
		for (int i = 0; i < 24; i++)
			send_pixel(OPENING[i], (i % 4) == 3);
		send_pixel(sod_pkg::FG_VALUE, 1'b1);
		wait_idle();

		// Random phases. Each phase fixes the settings and a frame length,
		// then sends a run of frames built from one scene with a few pixels
		// flipped. The mostly still content lets past frames agree. The
		// first phases are forced into the special corners: a frame tall
		// enough to pin the row at the bottom, an empty region, an inverted
		// region in each direction, and the extreme thresholds.
		for (phase = 0; pixels_sent < ITEM_TARGET; phase++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					plan.roi_x_min = 11'd0;
					plan.roi_x_max = 11'd1024;
					plan.roi_y_min = 10'd0;
					plan.roi_y_max = 10'd512;
				end
				6, 7: begin
					plan.roi_x_min = 11'($urandom_range(0, 8));
					plan.roi_x_max = 11'($urandom_range(plan.roi_x_min + 1, 40));
					plan.roi_y_min = 10'($urandom_range(0, 3));
					plan.roi_y_max = 10'($urandom_range(plan.roi_y_min + 1, 20));
				end
				default: begin
					plan.roi_x_min = 11'($urandom_range(0, 1024));
					plan.roi_x_max = 11'($urandom_range(0, 1024));
					plan.roi_y_min = 10'($urandom_range(0, 512));
					plan.roi_y_max = 10'($urandom_range(0, 512));
				end
			endcase
			// Keeping the row length across phases keeps the history settled.
			if ($urandom_range(0, 9) >= 6)
				plan.frame_width = ($urandom_range(0, 5) == 0) ? 11'd1024
					: 11'($urandom_range(1, 16));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: plan.min_foreground = 20'($urandom_range(0, 6));
				7, 8:                plan.min_foreground = 20'($urandom_range(0, 40));
				default:             plan.min_foreground = 20'($urandom_range(0, 524288));
			endcase
			plan.ratio_tenths = 4'($urandom_range(0, 10));
			plan.min_agreeing = 3'($urandom_range(0, 5));
			frame_len = $urandom_range(4, 40);
			frame_total = $urandom_range(8, 14);

			case (phase)
				0: begin
					// One pixel per row: the frame runs past the last row.
					plan.frame_width = 11'd1;
					frame_len = 514;
					frame_total = 1;
				end
				1: plan.roi_x_max = plan.roi_x_min;
				2: begin
					plan.roi_x_min = 11'd1024;
					plan.roi_x_max = 11'd0;
				end
				3: begin
					plan.roi_y_min = 10'd512;
					plan.roi_y_max = 10'd0;
				end
				4: begin
					plan.min_agreeing = 3'd0;
					plan.min_foreground = 20'd0;
				end
				5: begin
					plan.min_agreeing = 3'd5;
					plan.ratio_tenths = 4'd0;
					plan.min_foreground = 20'd0;
				end
				6: begin
					plan.ratio_tenths = 4'd10;
					plan.min_foreground = 20'd524288;
					plan.frame_width = 11'd1024;
				end
				default: ;
			endcase
			apply_settings(plan);

			fill_pct = $urandom_range(20, 90);
			case ($urandom_range(0, 3))
				0:       drop_pct = 0;
				1:       drop_pct = 3;
				2:       drop_pct = 10;
				default: drop_pct = 50;
			endcase
			foreach (scene[i])
				scene[i] = ($urandom_range(0, 99) < fill_pct);

			for (int f = 0; f < frame_total; f++) begin
				len_now = frame_len;
				// Now and then a frame ends early or runs long.
				if (phase != 0 && $urandom_range(0, 9) == 0)
					len_now = $urandom_range(1, frame_len + 8);
				// Now and then part of the scene changes, as when an object
				// comes to rest or leaves.
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 8)) scene[$urandom_range(0, 63)] ^= 1'b1;
				for (int i = 0; i < len_now; i++) begin
					want_fg = scene[i % 64] ^ ($urandom_range(0, 99) < drop_pct);
					send_pixel(mask_for(want_fg), i == len_now - 1);
				end
			end
			wait_idle();
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("stationary_object_detector_top test passed");
		else
			$display("stationary_object_detector_top test failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/sod_pkg.sv
rtl/sod_raster.sv
rtl/sod_accum.sv
rtl/sod_judge.sv
rtl/sod_result_fifo.sv
rtl/stationary_object_detector_top.sv
rtl/sod_checker.sv
bench/tb_stationary_object_detector_top.sv
